>>> rtl/core/ipv4_rx_header_check_unit_assert.svh
// Assertion macros shared by the header check RTL.
`ifndef IPV4_RX_HEADER_CHECK_UNIT_ASSERT_SVH
`define IPV4_RX_HEADER_CHECK_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IPV4RX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IPV4RX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ipv4rx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipv4rx_pkg;

  typedef enum logic [2:0] {
    VERD_ACCEPT    = 3'd0,
    VERD_SHORT     = 3'd1,
    VERD_VERSION   = 3'd2,
    VERD_IHL       = 3'd3,
    VERD_TOTAL_LEN = 3'd4,
    VERD_CHECKSUM  = 3'd5,
    VERD_NOT_OURS  = 3'd6
  } verdict_e;

  typedef enum logic [1:0] {
    PCLS_ICMP  = 2'd0,
    PCLS_TCP   = 2'd1,
    PCLS_UDP   = 2'd2,
    PCLS_OTHER = 2'd3
  } proto_class_e;

  localparam logic [7:0]  PROTO_ICMP    = 8'd1;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [3:0]  IP_VERSION    = 4'd4;
  localparam logic [5:0]  MIN_HDR_BYTES = 6'd20;
  localparam logic [15:0] SUM_GOOD      = 16'hFFFF;
  localparam logic [31:0] BCAST_ADDR    = 32'hFFFF_FFFF;

  // Header word positions (16-bit words from the start of the header)
  localparam logic [4:0] WIDX_TOTAL  = 5'd1;
  localparam logic [4:0] WIDX_PROTO  = 5'd4;
  localparam logic [4:0] WIDX_SRC_HI = 5'd6;
  localparam logic [4:0] WIDX_SRC_LO = 5'd7;
  localparam logic [4:0] WIDX_DST_HI = 5'd8;
  localparam logic [4:0] WIDX_DST_LO = 5'd9;

  typedef struct packed {
    verdict_e     verdict;
    proto_class_e proto_class;
    logic [7:0]   proto_num;
    logic [31:0]  src_ip;
    logic [31:0]  dst_ip;
    logic [5:0]   header_bytes;
    logic [15:0]  pay_bytes;
  } res_t;

  function automatic proto_class_e class_of(input logic [7:0] proto);
    proto_class_e cls;
    priority if (proto == PROTO_ICMP) cls = PCLS_ICMP;
    else if (proto == PROTO_TCP) cls = PCLS_TCP;
    else if (proto == PROTO_UDP) cls = PCLS_UDP;
    else cls = PCLS_OTHER;
    return cls;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ipv4rx_hdr_proc.sv
`timescale 1ns / 1ps
`default_nettype none

module ipv4rx_hdr_proc
  import ipv4rx_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] local_addr_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] word_i,
  input  wire logic        first_i,
  input  wire logic [15:0] frame_len_i,
  input  wire logic        res_space_i,
  output logic             res_valid_o,
  output res_t             res_o
);

  // Input stage
  logic        s1_valid_q, s1_valid_d;
  logic [15:0] word_q;
  logic        first_q;
  logic [15:0] frame_len_q;
  logic        in_fire, s1_fire;

  // Header state
  logic        in_header_q, in_header_d;
  logic [4:0]  word_index_q, word_index_d;
  logic [4:0]  header_words_q, header_words_d;
  logic [15:0] sum_acc_q, sum_acc_d;
  logic [15:0] frame_bytes_q, frame_bytes_d;
  logic [15:0] total_bytes_q, total_bytes_d;
  logic [7:0]  proto_field_q, proto_field_d;
  logic [31:0] src_field_q, src_field_d;
  logic [31:0] dst_field_q, dst_field_d;

  logic [16:0] sum_wide;
  logic [15:0] sum_fold;
  logic [5:0]  hb_first;
  logic [5:0]  hb_res;
  logic        emit;
  logic        early;
  verdict_e    verd;

  assign in_ready_o = !s1_valid_q || res_space_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_fire    = s1_valid_q && res_space_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  assign hb_first = {word_q[11:8], 2'b00};
  assign sum_wide = {1'b0, sum_acc_q} + {1'b0, word_q};
  assign sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};

  always_comb begin
    in_header_d    = in_header_q;
    word_index_d   = word_index_q;
    header_words_d = header_words_q;
    sum_acc_d      = sum_acc_q;
    frame_bytes_d  = frame_bytes_q;
    total_bytes_d  = total_bytes_q;
    proto_field_d  = proto_field_q;
    src_field_d    = src_field_q;
    dst_field_d    = dst_field_q;
    emit           = 1'b0;
    verd           = VERD_ACCEPT;

    if (s1_fire) begin
      if (first_q) begin
        frame_bytes_d  = frame_len_q;
        header_words_d = {word_q[11:8], 1'b0};
        word_index_d   = 5'd1;
        sum_acc_d      = word_q;
        total_bytes_d  = 16'd0;
        proto_field_d  = 8'd0;
        src_field_d    = 32'd0;
        dst_field_d    = 32'd0;
        in_header_d    = 1'b1;
        priority if (frame_len_q < {10'd0, MIN_HDR_BYTES}) begin
          emit = 1'b1;
          verd = VERD_SHORT;
        end else if (word_q[15:12] != IP_VERSION) begin
          emit = 1'b1;
          verd = VERD_VERSION;
        end else if (hb_first < MIN_HDR_BYTES || {10'd0, hb_first} > frame_len_q) begin
          emit = 1'b1;
          verd = VERD_IHL;
        end else begin
          emit = 1'b0;
        end
      end else if (in_header_q) begin
        sum_acc_d    = sum_fold;
        word_index_d = word_index_q + 5'd1;
        unique case (word_index_q)
          WIDX_TOTAL:  total_bytes_d = word_q;
          WIDX_PROTO:  proto_field_d = word_q[7:0];
          WIDX_SRC_HI: src_field_d   = {word_q, src_field_q[15:0]};
          WIDX_SRC_LO: src_field_d   = {src_field_q[31:16], word_q};
          WIDX_DST_HI: dst_field_d   = {word_q, dst_field_q[15:0]};
          WIDX_DST_LO: dst_field_d   = {dst_field_q[31:16], word_q};
          default: ;
        endcase
        priority if (word_index_q == WIDX_TOTAL &&
                     (word_q > frame_bytes_q ||
                      word_q < {10'd0, header_words_q, 1'b0})) begin
          emit = 1'b1;
          verd = VERD_TOTAL_LEN;
        end else if (word_index_d >= header_words_q) begin
          emit = 1'b1;
          priority if (sum_fold != SUM_GOOD) begin
            verd = VERD_CHECKSUM;
          end else if (local_addr_i != 32'd0 && dst_field_d != local_addr_i &&
                       dst_field_d != BCAST_ADDR) begin
            verd = VERD_NOT_OURS;
          end else begin
            verd = VERD_ACCEPT;
          end
        end else begin
          emit = 1'b0;
        end
      end
      if (emit) begin
        in_header_d = 1'b0;
      end
    end
  end

  assign early  = (verd == VERD_SHORT) || (verd == VERD_VERSION) ||
                  (verd == VERD_IHL) || (verd == VERD_TOTAL_LEN);
  assign hb_res = {header_words_d, 1'b0};

  always_comb begin
    res_valid_o        = emit;
    res_o.verdict      = verd;
    res_o.proto_class  = early ? PCLS_OTHER : class_of(proto_field_d);
    res_o.proto_num    = early ? 8'd0 : proto_field_d;
    res_o.src_ip       = early ? 32'd0 : src_field_d;
    res_o.dst_ip       = early ? 32'd0 : dst_field_d;
    res_o.header_bytes = hb_res;
    res_o.pay_bytes    = (verd == VERD_ACCEPT) ? (total_bytes_d - {10'd0, hb_res}) : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      in_header_q    <= 1'b0;
      word_index_q   <= 5'd0;
      header_words_q <= 5'd0;
    end else begin
      s1_valid_q     <= s1_valid_d;
      in_header_q    <= in_header_d;
      word_index_q   <= word_index_d;
      header_words_q <= header_words_d;
    end
  end

  // Datapath: hold the beat and header fields, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      word_q      <= word_i;
      first_q     <= first_i;
      frame_len_q <= frame_len_i;
    end
    sum_acc_q     <= sum_acc_d;
    frame_bytes_q <= frame_bytes_d;
    total_bytes_q <= total_bytes_d;
    proto_field_q <= proto_field_d;
    src_field_q   <= src_field_d;
    dst_field_q   <= dst_field_d;
  end

  `include "ipv4_rx_header_check_unit_assert.svh"

  `IPV4RX_ASSERT_NOW(a_index_in_header, in_header_q, word_index_q < header_words_q, "word index past header end")
  `IPV4RX_ASSERT_NOW(a_early_zero_fields, res_valid_o && early, res_o.src_ip == 32'd0 && res_o.dst_ip == 32'd0 && res_o.proto_class == PCLS_OTHER, "early verdict with header fields")
  `IPV4RX_ASSERT_NOW(a_payload_on_accept, res_valid_o && res_o.verdict != VERD_ACCEPT, res_o.pay_bytes == 16'd0, "payload length on rejected packet")
  `IPV4RX_ASSERT_NEXT(a_emit_closes, res_valid_o, !in_header_q, "header still open after verdict")

endmodule

`default_nettype wire

>>> rtl/core/ipv4rx_res_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module ipv4rx_res_fifo
  import ipv4rx_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  res_t      push_data_i,
  output logic      space_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      out_data_o
);

  res_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign space_o     = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = slot_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  `include "ipv4_rx_header_check_unit_assert.svh"

  `IPV4RX_ASSERT_NOW(a_no_overflow, push_i, count_q != 2'd2, "result pushed into full queue")
  `IPV4RX_ASSERT_NOW(a_count_range, 1'b1, count_q != 2'd3, "result queue count out of range")
  `IPV4RX_ASSERT_NEXT(a_drain_last, pop && !push_i && count_q == 2'd1, count_q == 2'd0, "queue did not drain")

endmodule

`default_nettype wire

>>> rtl/core/ipv4_rx_header_check_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// IPv4 receive header checker. Feed the datagram one big-endian 16-bit word per beat,
// with first_i set on the first word (frame_len_i is sampled there); one verdict beat
// comes out per datagram, after the last header word or earlier on a short frame, bad
// version, bad IHL or bad total length. Payload words after the header give no result.
// It takes one word every cycle while in_ready_o is high: each beat is registered,
// checked combinationally against the running checksum and latched fields, and its
// verdict goes into a two-entry result queue. in_ready_o drops only while that queue
// is full and a beat waits in the input register. local_addr sits at APB address 0
// (zero accepts any destination); write it only while the block idles (not enforced).
module ipv4_rx_header_check_unit
  import ipv4rx_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Word input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] word_i,
  input  wire logic        first_i,
  input  wire logic [15:0] frame_len_i,
  // Verdict output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       verdict_o,
  output logic [1:0]       proto_class_o,
  output logic [7:0]       proto_num_o,
  output logic [31:0]      src_ip_o,
  output logic [31:0]      dst_ip_o,
  output logic [5:0]       header_bytes_o,
  output logic [15:0]      pay_bytes_o
);

  logic [31:0] local_addr_q, local_addr_d;
  logic        reg_sel;
  logic        res_valid;
  logic        res_space;
  res_t        res;
  res_t        out_res;

  assign reg_sel = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? local_addr_q : 32'd0;

  always_comb begin
    local_addr_d = local_addr_q;
    if (psel && penable && pwrite && reg_sel) begin
      local_addr_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_addr_q <= 32'd0;
    end else begin
      local_addr_q <= local_addr_d;
    end
  end

  ipv4rx_hdr_proc u_proc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .local_addr_i (local_addr_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .word_i       (word_i),
    .first_i      (first_i),
    .frame_len_i  (frame_len_i),
    .res_space_i  (res_space),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  ipv4rx_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (res_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign verdict_o      = out_res.verdict;
  assign proto_class_o  = out_res.proto_class;
  assign proto_num_o    = out_res.proto_num;
  assign src_ip_o       = out_res.src_ip;
  assign dst_ip_o       = out_res.dst_ip;
  assign header_bytes_o = out_res.header_bytes;
  assign pay_bytes_o    = out_res.pay_bytes;

endmodule

`default_nettype wire
